FILE: hdl/strongly_connected_components_unit_assert.svh
// Assertion helpers for the strongly connected components unit.
// The asserting module provides clk and arst_n.
`ifndef STRONGLY_CONNECTED_COMPONENTS_UNIT_ASSERT_SVH
`define STRONGLY_CONNECTED_COMPONENTS_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SCCU_ASSERT_IMP(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("sccu check failed");

// Next-cycle implication.
`define SCCU_ASSERT_NXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("sccu check failed");

`endif

FILE: hdl/sccu_pkg.sv
package sccu_pkg;

	localparam int VW   = 6;
	localparam int CFGW = 7;
	localparam int OPW  = 2;
	localparam int STW  = 2;

	localparam logic [OPW-1:0] OP_ADD     = 2'd0;
	localparam logic [OPW-1:0] OP_COMPUTE = 2'd1;
	localparam logic [OPW-1:0] OP_CLEAR   = 2'd2;

	localparam logic [STW-1:0] STAT_OK    = 2'd0;
	localparam logic [STW-1:0] STAT_FULL  = 2'd1;
	localparam logic [STW-1:0] STAT_RANGE = 2'd2;

	localparam logic [CFGW-1:0] VCOUNT_RESET = 7'd64;

	typedef struct packed {
		logic add;
		logic clear;
		logic rd;
	} edge_cmd_t;

endpackage

FILE: hdl/sccu_req_if.sv
interface sccu_req_if import sccu_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [OPW-1:0] op;
	logic [VW-1:0]  src;
	logic [VW-1:0]  dst;

	modport source (output valid, output op, output src, output dst, input ready);
	modport sink   (input valid, input op, input src, input dst, output ready);
endinterface

FILE: hdl/sccu_rsp_if.sv
interface sccu_rsp_if import sccu_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [STW-1:0] status;
	logic [VW-1:0]  vertex;
	logic [VW-1:0]  component;
	logic           component_end;
	logic           last;

	modport source (output valid, output status, output vertex, output component,
		output component_end, output last, input ready);
	modport sink   (input valid, input status, input vertex, input component,
		input component_end, input last, output ready);
endinterface

FILE: hdl/strongly_connected_components_unit.sv
// Strongly connected components unit (Kosaraju).
// req carries op/src/dst; rsp returns status/vertex/component/component_end/last.
// cfg_data sets vertex_count; the user must write it only while the unit is idle, which
// the unit does not enforce; cfg_ready is always high. An add or clear item gives one
// registered result, on rsp in the cycle after acceptance; with rsp taken every cycle the
// unit takes one such item per cycle. A compute gives n_w results, one per vertex, and
// req.ready stays low until the last is loaded. Compute runs in steps of one memory access:
//   first pass, a scan of the stored edges from each stack entry plus a visit per vertex,
//   an adjacency clearing sweep, one row per vertex,
//   an adjacency build over each stored edge,
//   second pass, a visit per vertex and per stack pop.
// A stalled rsp holds the result register and freezes the walk at the next result.
// Reset empties the edge store, sets vertex_count to 64 and drops all pending results;
// memories need no clearing pass.
module strongly_connected_components_unit import sccu_pkg::*; #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 512
) (
	input  logic              clk,
	input  logic              arst_n,
	sccu_req_if.sink          req,
	sccu_rsp_if.source        rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFGW-1:0]   cfg_data
);

	`include "strongly_connected_components_unit_assert.svh"

	localparam int VIW  = $clog2(MAX_VERTICES);
	localparam int SPW  = $clog2(MAX_VERTICES + 1);
	localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW  = $clog2(MAX_EDGES + 1);
	localparam int CURW = (ECW > SPW) ? ECW : SPW;

	typedef struct packed {
		logic [VW-1:0]   v;
		logic [CURW-1:0] cur;
	} stack_ent_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_P1_ROOT, ST_P1_RD, ST_P1_CHK, ST_P1_POP,
		ST_B_CLR, ST_B_RD, ST_B_ADJ, ST_B_WR,
		ST_P2_ROOT, ST_P2_RCHK, ST_P2_RD, ST_P2_CHK, ST_P2_POP, ST_P2_DONE
	} state_t;

	state_t               state_q;
	logic [CFGW-1:0]      vcount_q;
	logic [CFGW-1:0]      r_q;
	logic [VW-1:0]        top_v_q;
	logic [CURW-1:0]      top_cur_q;
	logic [SPW-1:0]       sp_q;
	logic [SPW-1:0]       fin_q;
	logic [ECW-1:0]       idx_q;
	logic [VIW-1:0]       ri_q;
	logic [VW-1:0]        comp_q;
	logic [VW-1:0]        pend_v_q;
	logic [VW-1:0]        pend_comp_q;
	logic                 pend_cend_q;
	logic                 pend_valid_q;
	logic [MAX_VERTICES-1:0] visited_q;

	logic                 out_valid_q;
	logic [STW-1:0]       out_status_q;
	logic [VW-1:0]        out_vertex_q;
	logic [VW-1:0]        out_comp_q;
	logic                 out_cend_q;
	logic                 out_last_q;

	stack_ent_t           stack_mem [MAX_VERTICES];
	stack_ent_t           stack_rd_q;
	logic [VW-1:0]        fin_mem [MAX_VERTICES];
	logic [VW-1:0]        fin_rd_q;
	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] adj_rd_q;

	edge_cmd_t            ecmd;
	logic [EAW-1:0]       e_rd_addr;
	logic [VW-1:0]        es_src;
	logic [VW-1:0]        es_dst;
	logic [ECW-1:0]       edge_total;
	logic                 edge_full;

	logic [CFGW-1:0]      n_w;
	logic                 out_free;
	logic                 out_load;
	logic                 in_acc;
	logic                 in_range;
	logic                 e_use;
	logic                 p1_hit;
	logic                 cur_end;
	logic                 b_end;
	logic [MAX_VERTICES-1:0] ge_mask;
	logic [MAX_VERTICES-1:0] cand;
	logic                 found;
	logic [VIW-1:0]       t_idx;

	logic                 stk_we;
	stack_ent_t           stk_wdata;
	logic [VIW-1:0]       stk_waddr;
	logic [VIW-1:0]       stk_raddr;
	logic                 fin_we;
	logic                 adj_we;
	logic [VIW-1:0]       adj_waddr;
	logic [MAX_VERTICES-1:0] adj_wdata;
	logic                 adj_re;
	logic [VIW-1:0]       adj_raddr;

	sccu_edge_store #(.MAX_EDGES(MAX_EDGES)) u_edges (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (ecmd),
		.wr_src  (req.src),
		.wr_dst  (req.dst),
		.rd_addr (e_rd_addr),
		.rd_src  (es_src),
		.rd_dst  (es_dst),
		.total   (edge_total),
		.full    (edge_full)
	);

	// Clamp the vertex count into 1..MAX_VERTICES.
	always_comb begin
		if (vcount_q == '0) begin
			n_w = CFGW'(1);
		end else if (vcount_q > CFGW'(MAX_VERTICES)) begin
			n_w = CFGW'(MAX_VERTICES);
		end else begin
			n_w = vcount_q;
		end
	end

	assign cfg_ready  = 1'b1;
	assign out_free   = !out_valid_q || rsp.ready;
	assign req.ready  = (state_q == ST_IDLE) && out_free;
	assign in_acc     = req.valid && req.ready;
	assign in_range   = (CFGW'(req.src) < n_w) && (CFGW'(req.dst) < n_w);

	assign e_use   = (CFGW'(es_src) < n_w) && (CFGW'(es_dst) < n_w);
	assign p1_hit  = e_use && (es_src == top_v_q) && !visited_q[es_dst[VIW-1:0]];
	assign cur_end = top_cur_q >= CURW'(edge_total);
	assign b_end   = idx_q >= edge_total;

	always_comb begin
		for (int k = 0; k < MAX_VERTICES; k++) begin
			ge_mask[k] = CURW'(k) >= top_cur_q;
		end
	end

	assign cand  = adj_rd_q & ~visited_q & ge_mask;
	assign found = |cand;

	always_comb begin
		t_idx = '0;
		for (int k = MAX_VERTICES - 1; k >= 0; k--) begin
			if (cand[k]) begin
				t_idx = VIW'(k);
			end
		end
	end

	// Load the result register with a new item.
	assign out_load =
		((state_q == ST_IDLE) && in_acc && ((req.op == OP_ADD) || (req.op == OP_CLEAR))) ||
		((state_q == ST_P2_RCHK) && !visited_q[fin_rd_q[VIW-1:0]] && pend_valid_q &&
			out_free) ||
		((state_q == ST_P2_CHK) && found && out_free) ||
		((state_q == ST_P2_DONE) && out_free);

	// Memory and edge store controls.
	always_comb begin
		ecmd.add  = in_acc && (req.op == OP_ADD) && in_range;
		ecmd.clear = in_acc && (req.op == OP_CLEAR);
		ecmd.rd   = ((state_q == ST_P1_RD) && !cur_end) || ((state_q == ST_B_RD) && !b_end);
		e_rd_addr = (state_q == ST_P1_RD) ? top_cur_q[EAW-1:0] : idx_q[EAW-1:0];

		stk_we    = ((state_q == ST_P1_CHK) && p1_hit) ||
			((state_q == ST_P2_CHK) && found && out_free);
		stk_waddr = VIW'(sp_q - 1'b1);
		stk_raddr = VIW'(sp_q - 2'd2);
		stk_wdata.v   = top_v_q;
		stk_wdata.cur = (state_q == ST_P1_CHK) ? top_cur_q + 1'b1 : CURW'(t_idx) + 1'b1;

		fin_we    = (state_q == ST_P1_RD) && cur_end;

		adj_we    = (state_q == ST_B_CLR) || (state_q == ST_B_WR);
		adj_waddr = (state_q == ST_B_CLR) ? r_q[VIW-1:0] : es_dst[VIW-1:0];
		adj_wdata = (state_q == ST_B_CLR) ? '0 :
			adj_rd_q | (MAX_VERTICES'(1) << es_src[VIW-1:0]);
		adj_re    = ((state_q == ST_B_ADJ) && e_use) || (state_q == ST_P2_RD);
		adj_raddr = (state_q == ST_P2_RD) ? top_v_q[VIW-1:0] : es_dst[VIW-1:0];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_waddr] <= stk_wdata;
		end
		stack_rd_q <= stack_mem[stk_raddr];
	end

	always_ff @(posedge clk) begin
		if (fin_we) begin
			fin_mem[fin_q[VIW-1:0]] <= top_v_q;
		end
		fin_rd_q <= fin_mem[ri_q];
	end

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[adj_waddr] <= adj_wdata;
		end
		if (adj_re) begin
			adj_rd_q <= adj_mem[adj_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			vcount_q     <= VCOUNT_RESET;
			r_q          <= '0;
			top_v_q      <= '0;
			top_cur_q    <= '0;
			sp_q         <= '0;
			fin_q        <= '0;
			idx_q        <= '0;
			ri_q         <= '0;
			comp_q       <= '0;
			pend_v_q     <= '0;
			pend_comp_q  <= '0;
			pend_cend_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			visited_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= STAT_OK;
			out_vertex_q <= '0;
			out_comp_q   <= '0;
			out_cend_q   <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				vcount_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (req.op)
							OP_ADD, OP_CLEAR: begin
								out_vertex_q <= '0;
								out_comp_q   <= '0;
								out_cend_q   <= 1'b0;
								out_last_q   <= 1'b1;
								if (req.op == OP_CLEAR) begin
									out_status_q <= STAT_OK;
								end else if (!in_range) begin
									out_status_q <= STAT_RANGE;
								end else if (edge_full) begin
									out_status_q <= STAT_FULL;
								end else begin
									out_status_q <= STAT_OK;
								end
							end
							OP_COMPUTE: begin
								visited_q <= '0;
								r_q       <= '0;
								fin_q     <= '0;
								sp_q      <= '0;
								state_q   <= ST_P1_ROOT;
							end
							default: begin
								// undefined op: drop it
							end
						endcase
					end
				end

				ST_P1_ROOT: begin
					if (r_q == n_w) begin
						r_q     <= '0;
						state_q <= ST_B_CLR;
					end else if (visited_q[r_q[VIW-1:0]]) begin
						r_q <= r_q + 1'b1;
					end else begin
						visited_q[r_q[VIW-1:0]] <= 1'b1;
						top_v_q   <= r_q[VW-1:0];
						top_cur_q <= '0;
						sp_q      <= SPW'(1);
						state_q   <= ST_P1_RD;
					end
				end

				ST_P1_RD: begin
					if (cur_end) begin
						// vertex finished: record it and pop
						fin_q <= fin_q + 1'b1;
						if (sp_q == SPW'(1)) begin
							sp_q    <= '0;
							state_q <= ST_P1_ROOT;
						end else begin
							sp_q    <= sp_q - 1'b1;
							state_q <= ST_P1_POP;
						end
					end else begin
						state_q <= ST_P1_CHK;
					end
				end

				ST_P1_CHK: begin
					if (p1_hit) begin
						visited_q[es_dst[VIW-1:0]] <= 1'b1;
						top_v_q   <= es_dst;
						top_cur_q <= '0;
						sp_q      <= sp_q + 1'b1;
					end else begin
						top_cur_q <= top_cur_q + 1'b1;
					end
					state_q <= ST_P1_RD;
				end

				ST_P1_POP: begin
					top_v_q   <= stack_rd_q.v;
					top_cur_q <= stack_rd_q.cur;
					state_q   <= ST_P1_RD;
				end

				ST_B_CLR: begin
					if (r_q == n_w - 1'b1) begin
						idx_q   <= '0;
						state_q <= ST_B_RD;
					end else begin
						r_q <= r_q + 1'b1;
					end
				end

				ST_B_RD: begin
					if (b_end) begin
						visited_q    <= '0;
						ri_q         <= VIW'(fin_q - 1'b1);
						comp_q       <= '0;
						pend_valid_q <= 1'b0;
						state_q      <= ST_P2_ROOT;
					end else begin
						state_q <= ST_B_ADJ;
					end
				end

				ST_B_ADJ: begin
					if (e_use) begin
						state_q <= ST_B_WR;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_B_RD;
					end
				end

				ST_B_WR: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= ST_B_RD;
				end

				ST_P2_ROOT: begin
					state_q <= ST_P2_RCHK;
				end

				ST_P2_RCHK: begin
					if (visited_q[fin_rd_q[VIW-1:0]]) begin
						if (ri_q == '0) begin
							state_q <= ST_P2_DONE;
						end else begin
							ri_q    <= ri_q - 1'b1;
							state_q <= ST_P2_ROOT;
						end
					end else if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							out_status_q <= STAT_OK;
							out_vertex_q <= pend_v_q;
							out_comp_q   <= pend_comp_q;
							out_cend_q   <= pend_cend_q;
							out_last_q   <= 1'b0;
						end
						pend_v_q     <= fin_rd_q;
						pend_comp_q  <= comp_q;
						pend_cend_q  <= 1'b0;
						pend_valid_q <= 1'b1;
						visited_q[fin_rd_q[VIW-1:0]] <= 1'b1;
						top_v_q   <= fin_rd_q;
						top_cur_q <= '0;
						sp_q      <= SPW'(1);
						state_q   <= ST_P2_RD;
					end
				end

				ST_P2_RD: begin
					state_q <= ST_P2_CHK;
				end

				ST_P2_CHK: begin
					if (found) begin
						// hold until the previous vertex can leave
						if (out_free) begin
							out_status_q <= STAT_OK;
							out_vertex_q <= pend_v_q;
							out_comp_q   <= pend_comp_q;
							out_cend_q   <= pend_cend_q;
							out_last_q   <= 1'b0;
							pend_v_q     <= VW'(t_idx);
							pend_comp_q  <= comp_q;
							pend_cend_q  <= 1'b0;
							visited_q[t_idx] <= 1'b1;
							top_v_q   <= VW'(t_idx);
							top_cur_q <= '0;
							sp_q      <= sp_q + 1'b1;
							state_q   <= ST_P2_RD;
						end
					end else if (sp_q == SPW'(1)) begin
						// component closed
						pend_cend_q <= 1'b1;
						comp_q      <= comp_q + 1'b1;
						sp_q        <= '0;
						if (ri_q == '0) begin
							state_q <= ST_P2_DONE;
						end else begin
							ri_q    <= ri_q - 1'b1;
							state_q <= ST_P2_ROOT;
						end
					end else begin
						sp_q    <= sp_q - 1'b1;
						state_q <= ST_P2_POP;
					end
				end

				ST_P2_POP: begin
					top_v_q   <= stack_rd_q.v;
					top_cur_q <= stack_rd_q.cur;
					state_q   <= ST_P2_RD;
				end

				ST_P2_DONE: begin
					if (out_free) begin
						out_status_q <= STAT_OK;
						out_vertex_q <= pend_v_q;
						out_comp_q   <= pend_comp_q;
						out_cend_q   <= pend_cend_q;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.vertex        = out_vertex_q;
	assign rsp.component     = out_comp_q;
	assign rsp.component_end = out_cend_q;
	assign rsp.last          = out_last_q;

	`SCCU_ASSERT_IMP(a_stack_bound, state_q != ST_IDLE, CFGW'(sp_q) <= n_w)
	`SCCU_ASSERT_IMP(a_all_finished, state_q == ST_B_CLR, CFGW'(fin_q) == n_w)
	`SCCU_ASSERT_NXT(a_done_to_idle, (state_q == ST_P2_DONE) && out_free,
		out_valid_q && out_last_q && out_cend_q && (state_q == ST_IDLE))
	`SCCU_ASSERT_IMP(a_pend_in_walk, (state_q == ST_P2_RD) || (state_q == ST_P2_CHK),
		pend_valid_q && (sp_q != '0))

endmodule

FILE: hdl/sccu_edge_store.sv
module sccu_edge_store import sccu_pkg::*; #(
	parameter int MAX_EDGES = 512,
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
	localparam int ECW = $clog2(MAX_EDGES + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  edge_cmd_t       cmd,
	input  logic [VW-1:0]   wr_src,
	input  logic [VW-1:0]   wr_dst,
	input  logic [EAW-1:0]  rd_addr,
	output logic [VW-1:0]   rd_src,
	output logic [VW-1:0]   rd_dst,
	output logic [ECW-1:0]  total,
	output logic            full
);

	logic [2*VW-1:0] mem [MAX_EDGES];

	assign full = (total == ECW'(MAX_EDGES));

	always_ff @(posedge clk) begin
		if (cmd.add && !full) begin
			mem[total[EAW-1:0]] <= {wr_src, wr_dst};
		end
		if (cmd.rd) begin
			{rd_src, rd_dst} <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total <= '0;
		end else if (cmd.clear) begin
			total <= '0;
		end else if (cmd.add && !full) begin
			total <= total + 1'b1;
		end
	end

endmodule
